@@ hdl/rvd_pkg.sv @@
// ----------------------------------------------------------------------------
// rvd_pkg: shared definitions for the radix digit formatter
// Widths, character codes, register indexes, sequencer states and the
// symbol lookup used by the formatter core and its sub-blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package rvd_pkg;

    // Sizes of the value, the digits and the characters.
    localparam int WORD_W          = 32;
    localparam int DIGIT_W         = 4;
    localparam int CHAR_W          = 8;
    localparam int RADIX_W         = 5;
    localparam int CFG_W           = 64;
    localparam int CFG_INDEX_W     = 2;
    localparam int MAX_DIGITS      = 32;
    localparam int MAX_SYMBOLS     = 16;
    localparam int SYM_MAP_W       = 2 * CFG_W;

    // The divider retires this many quotient bits per cycle.
    localparam int STEP_BITS       = 8;
    localparam int STEPS_PER_DIGIT = WORD_W / STEP_BITS;
    localparam int STEP_CNT_W      = $clog2(STEPS_PER_DIGIT);

    // Digit store addressing and digit count.
    localparam int ADDR_W          = $clog2(MAX_DIGITS);
    localparam int COUNT_W         = $clog2(MAX_DIGITS + 1);

    // Character and radix constants.
    localparam logic [CHAR_W-1:0]  MINUS_CHAR  = 8'h2D;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(MAX_SYMBOLS);

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_RADIX        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

    // Write and read controls for the digit store.
    typedef struct packed {
        logic               wr_en;
        logic [ADDR_W-1:0]  wr_addr;
        logic [DIGIT_W-1:0] wr_data;
        logic [ADDR_W-1:0]  rd_addr;
    } store_ctrl_t;

    // Character for a digit value: one byte per digit, digit 0 lowest.
    function automatic logic [CHAR_W-1:0] symbol_for(
        input logic [SYM_MAP_W-1:0] sym_map,
        input logic [DIGIT_W-1:0]   digit
    );
        logic [6:0] base;
        base = {digit, 3'b000};
        return sym_map[base +: CHAR_W];
    endfunction

endpackage

`default_nettype wire

@@ hdl/rvd_div_step.sv @@
// ----------------------------------------------------------------------------
// rvd_div_step: shared short-division unit
// Divides a partial remainder followed by one byte of the dividend by the
// radix, giving one byte of quotient and the new remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module rvd_div_step
    import rvd_pkg::*;
(
    input  wire logic [DIGIT_W-1:0]   rem_in,
    input  wire logic [STEP_BITS-1:0] bits_in,
    input  wire logic [RADIX_W-1:0]   divisor,
    output logic      [STEP_BITS-1:0] quot_out,
    output logic      [DIGIT_W-1:0]   rem_out
);

    // Restoring division, one bit per step, most significant bit first.
    // The remainder stays below the divisor, so a five-bit trial fits.
    always_comb
    begin
        logic [RADIX_W-1:0] trial;
        logic [DIGIT_W-1:0] rem;
        rem      = rem_in;
        quot_out = '0;
        for (int i = STEP_BITS - 1; i >= 0; i--)
        begin
            trial = {rem, bits_in[i]};
            if (trial >= divisor)
            begin
                trial       = trial - divisor;
                quot_out[i] = 1'b1;
            end
            rem = trial[DIGIT_W-1:0];
        end
        rem_out = rem;
    end

endmodule

`default_nettype wire

@@ hdl/rvd_digit_store.sv @@
// ----------------------------------------------------------------------------
// rvd_digit_store: digit register file
// Holds the digits of the current value, least significant first, written
// by the divider and read back in reverse order for output.
// ----------------------------------------------------------------------------
`default_nettype none

module rvd_digit_store
    import rvd_pkg::*;
(
    input  wire logic               clk,
    input  wire store_ctrl_t        ctrl,
    output logic      [DIGIT_W-1:0] rd_data
);

    logic [DIGIT_W-1:0] digits_reg [MAX_DIGITS];

    // Write port; contents are undefined until written.
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            digits_reg[ctrl.wr_addr] <= ctrl.wr_data;
        end
    end

    // Read port; the core registers the resulting character.
    assign rd_data = digits_reg[ctrl.rd_addr];

endmodule

`default_nettype wire

@@ hdl/value_to_radix_digits_core.sv @@
// The shared divider splits a value into D digits, retiring 8 quotient bits per cycle;
// the characters then follow, the sign first, each loaded when the output register is
// free or being taken. A new value is accepted only in the idle state, after the last
// character of the previous value has been loaded into the output register.
// Reset clears the sequencer and output valid; radix resets to 10 and symbols to 0.
// The digit store is not cleared and holds nothing until a value is converted.
// ----------------------------------------------------------------------------
// value_to_radix_digits_core: integer to text in a radix of 2 to 16
// Splits an unsigned magnitude into digits by repeated division by the
// radix and emits the characters, a minus sign first when requested.
// ----------------------------------------------------------------------------
`default_nettype none

module value_to_radix_digits_core
    import rvd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_wdata,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [WORD_W-1:0]      magnitude,
    input  wire logic                   negative,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic      [CHAR_W-1:0]      out_char,
    output logic                        last_char
);

    state_t                  state_reg, state_next;
    logic [RADIX_W-1:0]      radix_reg, radix_next;
    logic [CFG_W-1:0]        sym_low_reg, sym_low_next;
    logic [CFG_W-1:0]        sym_high_reg, sym_high_next;
    logic [WORD_W-1:0]       work_reg, work_next;
    logic [DIGIT_W-1:0]      rem_reg, rem_next;
    logic [RADIX_W-1:0]      divisor_reg, divisor_next;
    logic [STEP_CNT_W-1:0]   step_reg, step_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic [COUNT_W-1:0]      emit_reg, emit_next;
    logic                    sign_reg, sign_next;
    logic                    out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]       out_char_reg, out_char_next;
    logic                    last_char_reg, last_char_next;

    logic [STEP_BITS-1:0]    quot_bits;
    logic [DIGIT_W-1:0]      rem_step;
    logic [WORD_W-1:0]       work_shift;
    logic [COUNT_W-1:0]      count_inc;
    logic [COUNT_W-1:0]      emit_prev;
    logic [DIGIT_W-1:0]      rd_digit;
    logic [RADIX_W-1:0]      radix_eff;
    logic                    in_accept;
    logic                    last_step;
    logic                    digit_done;
    logic                    quot_zero;
    logic                    load_out;
    logic                    room;
    store_ctrl_t             store_ctrl;

    // Shared division unit, fed one dividend byte per cycle.
    rvd_div_step u_div_step (
        .rem_in   (rem_reg),
        .bits_in  (work_reg[WORD_W-1 -: STEP_BITS]),
        .divisor  (divisor_reg),
        .quot_out (quot_bits),
        .rem_out  (rem_step)
    );

    // Digit register file.
    rvd_digit_store u_digit_store (
        .clk     (clk),
        .ctrl    (store_ctrl),
        .rd_data (rd_digit)
    );

    // Helper terms for the sequencer and the datapath.
    assign work_shift = {work_reg[WORD_W-STEP_BITS-1:0], quot_bits};
    assign last_step  = (step_reg == STEP_CNT_W'(STEPS_PER_DIGIT - 1));
    assign quot_zero  = (work_shift == '0);
    assign room       = (count_reg < COUNT_W'(MAX_DIGITS));
    assign count_inc  = room ? (count_reg + COUNT_W'(1)) : count_reg;
    assign emit_prev  = emit_reg - COUNT_W'(1);
    assign in_accept  = in_valid && in_ready;

    // Radix clamped to the alphabet.
    always_comb
    begin
        if (radix_reg < RADIX_MIN)
        begin
            radix_eff = RADIX_MIN;
        end
        else if (radix_reg > RADIX_MAX)
        begin
            radix_eff = RADIX_MAX;
        end
        else
        begin
            radix_eff = radix_reg;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (last_step && quot_zero)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (load_out && !sign_reg && (emit_reg == COUNT_W'(1)))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ready   = 1'b0;
        digit_done = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_DIV:
            begin
                digit_done = last_step;
            end
            ST_EMIT:
            begin
                load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Digit store controls: write the finished digit, read the next to emit.
    always_comb
    begin
        store_ctrl.wr_en   = digit_done && room;
        store_ctrl.wr_addr = count_reg[ADDR_W-1:0];
        store_ctrl.wr_data = rem_step;
        store_ctrl.rd_addr = emit_prev[ADDR_W-1:0];
    end

    // Configuration writes; an unused index is ignored.
    always_comb
    begin
        radix_next    = radix_reg;
        sym_low_next  = sym_low_reg;
        sym_high_next = sym_high_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_RADIX:        radix_next    = cfg_wdata[RADIX_W-1:0];
                CFG_SYMBOLS_LOW:  sym_low_next  = cfg_wdata;
                CFG_SYMBOLS_HIGH: sym_high_next = cfg_wdata;
                default:          radix_next    = radix_reg;
            endcase
        end
    end

    // Division and emission datapath.
    always_comb
    begin
        work_next      = work_reg;
        rem_next       = rem_reg;
        divisor_next   = divisor_reg;
        step_next      = step_reg;
        count_next     = count_reg;
        emit_next      = emit_reg;
        sign_next      = sign_reg;
        out_char_next  = out_char_reg;
        last_char_next = last_char_reg;

        if (in_accept)
        begin
            work_next    = magnitude;
            rem_next     = '0;
            divisor_next = radix_eff;
            step_next    = '0;
            count_next   = '0;
            sign_next    = negative;
        end

        if (state_reg == ST_DIV)
        begin
            work_next = work_shift;
            rem_next  = rem_step;
            step_next = step_reg + STEP_CNT_W'(1);
            if (last_step)
            begin
                rem_next   = '0;
                count_next = count_inc;
                emit_next  = count_inc;
            end
        end

        if (load_out)
        begin
            if (sign_reg)
            begin
                out_char_next  = MINUS_CHAR;
                last_char_next = 1'b0;
                sign_next      = 1'b0;
            end
            else
            begin
                out_char_next  = symbol_for({sym_high_reg, sym_low_reg}, rd_digit);
                last_char_next = (emit_reg == COUNT_W'(1));
                emit_next      = emit_prev;
            end
        end
    end

    // Output register valid: set on load, cleared once the character is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            radix_reg     <= RADIX_RESET;
            sym_low_reg   <= '0;
            sym_high_reg  <= '0;
            step_reg      <= '0;
            count_reg     <= '0;
            emit_reg      <= '0;
            sign_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            radix_reg     <= radix_next;
            sym_low_reg   <= sym_low_next;
            sym_high_reg  <= sym_high_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            emit_reg      <= emit_next;
            sign_reg      <= sign_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        work_reg      <= work_next;
        rem_reg       <= rem_next;
        divisor_reg   <= divisor_next;
        out_char_reg  <= out_char_next;
        last_char_reg <= last_char_next;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last_char = last_char_reg;

endmodule

`default_nettype wire
